>>> hw/rtl/fsbd_pkg.sv
// shared types, constants and fp16 decode for the four-bit super-block dequantizer
// no dependencies; imported by every other rtl file of the block
`default_nettype none

package fsbd_pkg;

   localparam int TDATA_IN_W  = 136;
   localparam int TDATA_OUT_W = 112;

   // register stages of one nibble lane, matched by the back end's valid and index pipe
   localparam int LANE_STAGES = 6;

   localparam logic [31:0] FP32_QNAN = 32'h7FC0_0000;
   localparam logic [30:0] FP32_INF  = 31'h7F80_0000;

   // front end control: take words, or fold the eight scale products after a header
   typedef enum logic {
      FS_IDLE,
      FS_FOLD
   } fsbd_front_state_type;

   // class of a decoded fp16 operand
   typedef enum logic [1:0] {
      HC_FINITE,
      HC_INF,
      HC_NAN
   } fsbd_hclass_type;

   // special outcome of a product or difference
   typedef enum logic [1:0] {
      SP_NONE,
      SP_INF,
      SP_NAN
   } fsbd_spec_type;

   // fp16 as sign, integer significand and exponent biased by 24 (value = man * 2^(eb-24))
   typedef struct packed {
      logic            sign;
      fsbd_hclass_type cls;
      logic [10:0]     man;
      logic [4:0]      eb;
   } fsbd_half_type;

   // one classified quant byte, front to back
   typedef struct packed {
      logic [15:0] half_scale;
      logic [15:0] half_min_scale;
      logic [5:0]  sc_a;
      logic [5:0]  m_a;
      logic [5:0]  sc_b;
      logic [5:0]  m_b;
      logic [7:0]  quant_byte;
      logic [6:0]  position;
      logic        last;
      logic [31:0] row_max;
   } fsbd_item_type;

   // operands of one nibble lane
   typedef struct packed {
      fsbd_half_type d;
      fsbd_half_type dmin;
      logic [5:0]    sc;
      logic [5:0]    mn;
      logic [3:0]    q;
   } fsbd_lane_in_type;

   function automatic fsbd_half_type fsbd_decode(input logic [15:0] h);
      fsbd_half_type r;
      r.sign = h[15];
      r.man  = {1'b1, h[9:0]};
      r.eb   = h[14:10] - 5'd1;
      r.cls  = HC_FINITE;
      if (h[14:10] == 5'd31) begin
         r.cls = (h[9:0] == 10'd0) ? HC_INF : HC_NAN;
      end else if (h[14:10] == 5'd0) begin
         r.man = {1'b0, h[9:0]};
         r.eb  = 5'd0;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/fsbd_front.sv
// front end: accepts words, holds the super-block header, folds the row maximum
// and classifies quant bytes into queue entries; uses fsbd_pkg
`default_nettype none

module fsbd_front
   import fsbd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [TDATA_IN_W-1:0] req_tdata,
   input  wire logic                  req_tuser,
   input  wire logic                  req_tlast,
   input  wire logic                  q_full,
   output logic                       q_push,
   output fsbd_item_type              q_item
);

   fsbd_front_state_type state_ff, state_in;

   logic [15:0] block_scale_ff;
   logic [15:0] block_min_scale_ff;
   logic [95:0] packed_ff;
   logic [6:0]  pos_ff;
   logic [31:0] rowmax_ff, rowmax_in;
   logic [3:0]  cnt_ff;

   logic          pv_ff;
   fsbd_spec_type pspec_ff, pspec_in;
   logic          psign_ff;
   logic [16:0]   pman_ff;
   logic [4:0]    peb_ff;

   logic accept, hdr_acc, qb_acc, fold_issue;
   fsbd_half_type dd;
   logic [11:0] fold_sm, sm_a, sm_b;
   logic [31:0] pbits;
   logic        pupdate;

   // scale in upper six bits, min in lower six
   function automatic logic [11:0] sub_block(input logic [95:0] p, input logic [2:0] j);
      logic [11:0] r;
      unique case (j)
         3'd0: r = {p[5:0],   p[37:32]};
         3'd1: r = {p[13:8],  p[45:40]};
         3'd2: r = {p[21:16], p[53:48]};
         3'd3: r = {p[29:24], p[61:56]};
         3'd4: r = {p[7:6],   p[67:64], p[39:38], p[71:68]};
         3'd5: r = {p[15:14], p[75:72], p[47:46], p[79:76]};
         3'd6: r = {p[23:22], p[83:80], p[55:54], p[87:84]};
         3'd7: r = {p[31:30], p[91:88], p[63:62], p[95:92]};
         default: r = '0;
      endcase
      return r;
   endfunction

   // ordered greater-than on non-nan float32
   function automatic logic fp_gt(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] ka, kb;
      ka = a[31] ? ~a : (a | 32'h8000_0000);
      kb = b[31] ? ~b : (b | 32'h8000_0000);
      return ((a[30:0] != 31'd0) || (b[30:0] != 31'd0)) && (ka > kb);
   endfunction

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FS_IDLE: if (hdr_acc) state_in = FS_FOLD;
         FS_FOLD: if (cnt_ff[3]) state_in = FS_IDLE;
         default: state_in = FS_IDLE;
      endcase
   end

   // outputs of the state machine
   always_comb begin
      req_tready = 1'b0;
      fold_issue = 1'b0;
      unique case (state_ff)
         FS_IDLE: req_tready = !q_full;
         FS_FOLD: fold_issue = !cnt_ff[3];
         default: req_tready = 1'b0;
      endcase
   end

   assign accept  = req_tvalid && req_tready;
   assign hdr_acc = accept && !req_tuser;
   assign qb_acc  = accept && req_tuser;

   // quant byte classification
   assign sm_a   = sub_block(packed_ff, {pos_ff[6:5], 1'b0});
   assign sm_b   = sub_block(packed_ff, {pos_ff[6:5], 1'b1});
   assign q_push = qb_acc;

   always_comb begin
      q_item.half_scale     = block_scale_ff;
      q_item.half_min_scale = block_min_scale_ff;
      q_item.sc_a           = sm_a[11:6];
      q_item.m_a            = sm_a[5:0];
      q_item.sc_b           = sm_b[11:6];
      q_item.m_b            = sm_b[5:0];
      q_item.quant_byte     = req_tdata[135:128];
      q_item.position       = pos_ff;
      q_item.last           = req_tlast;
      q_item.row_max        = rowmax_ff;
   end

   // fold: product of d and one sub-block scale per cycle
   assign dd      = fsbd_decode(block_scale_ff);
   assign fold_sm = sub_block(packed_ff, cnt_ff[2:0]);

   always_comb begin
      pspec_in = SP_NONE;
      if (dd.cls == HC_NAN || (dd.cls == HC_INF && fold_sm[11:6] == 6'd0)) begin
         pspec_in = SP_NAN;
      end else if (dd.cls == HC_INF) begin
         pspec_in = SP_INF;
      end
   end

   // product to float32 and compare against the running maximum
   always_comb begin
      logic [31:0] w;
      logic [4:0]  sh;
      logic [8:0]  ex;
      w  = {pman_ff, 15'd0};
      sh = 5'd0;
      if (w[31:16] == 16'd0) begin w = {w[15:0], 16'd0}; sh = sh + 5'd16; end
      if (w[31:24] == 8'd0)  begin w = {w[23:0], 8'd0};  sh = sh + 5'd8;  end
      if (w[31:28] == 4'd0)  begin w = {w[27:0], 4'd0};  sh = sh + 5'd4;  end
      if (w[31:30] == 2'd0)  begin w = {w[29:0], 2'd0};  sh = sh + 5'd2;  end
      if (w[31] == 1'b0)     begin w = {w[30:0], 1'b0};  sh = sh + 5'd1;  end
      ex = 9'd119 - {4'd0, sh} + {4'd0, peb_ff};
      if (pspec_ff == SP_INF) begin
         pbits = {psign_ff, FP32_INF};
      end else if (pman_ff == 17'd0) begin
         pbits = {psign_ff, 31'd0};
      end else begin
         pbits = {psign_ff, ex[7:0], w[30:8]};
      end
      pupdate = pv_ff && (pspec_ff != SP_NAN) && fp_gt(pbits, rowmax_ff);
   end

   always_comb begin
      rowmax_in = rowmax_ff;
      priority if (qb_acc && req_tlast) begin
         rowmax_in = 32'd0;
      end else if (pupdate) begin
         rowmax_in = pbits;
      end else begin
         rowmax_in = rowmax_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= FS_IDLE;
         block_scale_ff     <= '0;
         block_min_scale_ff <= '0;
         packed_ff          <= '0;
         pos_ff             <= '0;
         rowmax_ff          <= '0;
         cnt_ff             <= '0;
         pv_ff              <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rowmax_ff <= rowmax_in;
         pv_ff     <= fold_issue;
         if (hdr_acc) begin
            block_scale_ff     <= req_tdata[15:0];
            block_min_scale_ff <= req_tdata[31:16];
            packed_ff          <= req_tdata[127:32];
            pos_ff             <= '0;
            cnt_ff             <= '0;
         end else begin
            if (qb_acc) pos_ff <= pos_ff + 7'd1;
            if (fold_issue) cnt_ff <= cnt_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      pspec_ff <= pspec_in;
      psign_ff <= dd.sign;
      pman_ff  <= {6'd0, dd.man} * {11'd0, fold_sm[11:6]};
      peb_ff   <= dd.eb;
   end

endmodule

`default_nettype wire

>>> hw/rtl/fsbd_queue.sv
// two-entry queue of classified quant bytes between front and back
// uses fsbd_pkg for the entry type
`default_nettype none

module fsbd_queue
   import fsbd_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           push,
   input  wire fsbd_item_type  push_data,
   output logic                full,
   input  wire logic           pop,
   output fsbd_item_type       pop_data,
   output logic                empty
);

   fsbd_item_type mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;

   assign full     = cnt_ff == 2'd2;
   assign empty    = cnt_ff == 2'd0;
   assign pop_data = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= !wp_ff;
         if (pop)  rp_ff <= !rp_ff;
         if (push && !pop) cnt_ff <= cnt_ff + 2'd1;
         else if (pop && !push) cnt_ff <= cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= push_data;
   end

endmodule

`default_nettype wire

>>> hw/rtl/fsbd_lane.sv
// one nibble lane: d*sc*q - dmin*m, exact products, one rounding to nearest even
// six register stages with a shared advance enable; uses fsbd_pkg
`default_nettype none

module fsbd_lane
   import fsbd_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             en,
   input  wire fsbd_lane_in_type lane_in,
   output logic [31:0]           value
);

   // stage 1
   logic [9:0]    t1_ff;
   logic [16:0]   mm1_ff;
   logic [10:0]   md1_ff;
   logic [4:0]    ebd1_ff, ebm1_ff;
   logic          sd1_ff, sm1_ff, ss1_ff;
   fsbd_spec_type sp1_ff;
   // stage 2
   logic [20:0]   a2_ff;
   logic [16:0]   mm2_ff;
   logic [4:0]    ebd2_ff, ebm2_ff;
   logic          sd2_ff, sm2_ff, ss2_ff;
   fsbd_spec_type sp2_ff;
   // stage 3
   logic [50:0]   mag3_ff;
   logic [4:0]    eb3_ff;
   logic          zero3_ff, sg3_ff, ss3_ff;
   fsbd_spec_type sp3_ff;
   // stage 4 and 5
   logic [63:0]   w4_ff, w5_ff;
   logic [5:0]    sh4_ff, sh5_ff;
   logic [4:0]    eb4_ff, eb5_ff;
   logic          zero4_ff, zero5_ff, sg4_ff, sg5_ff, ss4_ff, ss5_ff;
   fsbd_spec_type sp4_ff, sp5_ff;
   // stage 6
   logic [31:0]   value_ff;

   fsbd_spec_type sp_in;
   logic          ss_in;

   // infinities and nans are settled up front
   always_comb begin
      logic t1zero, t1inf, t1nan, t2inf, t2nan;
      t1zero = (lane_in.sc == 6'd0) || (lane_in.q == 4'd0);
      t1inf  = (lane_in.d.cls == HC_INF) && !t1zero;
      t1nan  = (lane_in.d.cls == HC_NAN) || ((lane_in.d.cls == HC_INF) && t1zero);
      t2inf  = (lane_in.dmin.cls == HC_INF) && (lane_in.mn != 6'd0);
      t2nan  = (lane_in.dmin.cls == HC_NAN) ||
               ((lane_in.dmin.cls == HC_INF) && (lane_in.mn == 6'd0));
      sp_in  = SP_NONE;
      ss_in  = 1'b0;
      priority if (t1nan || t2nan ||
                   (t1inf && t2inf && lane_in.d.sign == lane_in.dmin.sign)) begin
         sp_in = SP_NAN;
      end else if (t1inf) begin
         sp_in = SP_INF;
         ss_in = lane_in.d.sign;
      end else if (t2inf) begin
         sp_in = SP_INF;
         ss_in = !lane_in.dmin.sign;
      end else begin
         sp_in = SP_NONE;
         ss_in = 1'b0;
      end
   end

   // exact difference on a common exponent
   logic [50:0] mag3_in;
   logic [4:0]  eb3_in;
   logic        zero3_in, sg3_in;

   always_comb begin
      logic [52:0] ax, bx, xs, ys, sum, mg;
      if (ebd2_ff >= ebm2_ff) begin
         ax     = {32'd0, a2_ff} << (ebd2_ff - ebm2_ff);
         bx     = {36'd0, mm2_ff};
         eb3_in = ebm2_ff;
      end else begin
         ax     = {32'd0, a2_ff};
         bx     = {36'd0, mm2_ff} << (ebm2_ff - ebd2_ff);
         eb3_in = ebd2_ff;
      end
      xs       = sd2_ff ? -ax : ax;
      ys       = sm2_ff ? -bx : bx;
      sum      = xs - ys;
      mg       = sum[52] ? -sum : sum;
      mag3_in  = mg[50:0];
      zero3_in = sum == 53'd0;
      // both terms zero keeps the ieee sign rule for x - y
      if (zero3_in) sg3_in = (a2_ff == 21'd0) && (mm2_ff == 17'd0) && sd2_ff && !sm2_ff;
      else          sg3_in = sum[52];
   end

   // normalise in two halves
   logic [63:0] w4_in, w5_in;
   logic [5:0]  sh4_in, sh5_in;

   always_comb begin
      w4_in  = {mag3_ff, 13'd0};
      sh4_in = 6'd0;
      if (w4_in[63:32] == 32'd0) begin w4_in = {w4_in[31:0], 32'd0}; sh4_in = sh4_in + 6'd32; end
      if (w4_in[63:48] == 16'd0) begin w4_in = {w4_in[47:0], 16'd0}; sh4_in = sh4_in + 6'd16; end
      if (w4_in[63:56] == 8'd0)  begin w4_in = {w4_in[55:0], 8'd0};  sh4_in = sh4_in + 6'd8;  end
   end

   always_comb begin
      w5_in  = w4_ff;
      sh5_in = sh4_ff;
      if (w5_in[63:60] == 4'd0) begin w5_in = {w5_in[59:0], 4'd0}; sh5_in = sh5_in + 6'd4; end
      if (w5_in[63:62] == 2'd0) begin w5_in = {w5_in[61:0], 2'd0}; sh5_in = sh5_in + 6'd2; end
      if (w5_in[63] == 1'b0)    begin w5_in = {w5_in[62:0], 1'b0}; sh5_in = sh5_in + 6'd1; end
   end

   // round to nearest even and pack
   logic [31:0] value_in;

   always_comb begin
      logic [8:0]  ex;
      logic        inc;
      logic [30:0] body;
      ex   = 9'd153 - {3'd0, sh5_ff} + {4'd0, eb5_ff};
      inc  = w5_ff[39] && ((|w5_ff[38:0]) || w5_ff[40]);
      body = {ex[7:0], w5_ff[62:40]} + {30'd0, inc};
      unique case (sp5_ff)
         SP_NAN:  value_in = FP32_QNAN;
         SP_INF:  value_in = {ss5_ff, FP32_INF};
         default: value_in = zero5_ff ? {sg5_ff, 31'd0} : {sg5_ff, body};
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t1_ff    <= {4'd0, lane_in.sc} * {6'd0, lane_in.q};
         mm1_ff   <= {6'd0, lane_in.dmin.man} * {11'd0, lane_in.mn};
         md1_ff   <= lane_in.d.man;
         ebd1_ff  <= lane_in.d.eb;
         ebm1_ff  <= lane_in.dmin.eb;
         sd1_ff   <= lane_in.d.sign;
         sm1_ff   <= lane_in.dmin.sign;
         sp1_ff   <= sp_in;
         ss1_ff   <= ss_in;

         a2_ff    <= {10'd0, md1_ff} * {11'd0, t1_ff};
         mm2_ff   <= mm1_ff;
         ebd2_ff  <= ebd1_ff;
         ebm2_ff  <= ebm1_ff;
         sd2_ff   <= sd1_ff;
         sm2_ff   <= sm1_ff;
         sp2_ff   <= sp1_ff;
         ss2_ff   <= ss1_ff;

         mag3_ff  <= mag3_in;
         eb3_ff   <= eb3_in;
         zero3_ff <= zero3_in;
         sg3_ff   <= sg3_in;
         sp3_ff   <= sp2_ff;
         ss3_ff   <= ss2_ff;

         w4_ff    <= w4_in;
         sh4_ff   <= sh4_in;
         eb4_ff   <= eb3_ff;
         zero4_ff <= zero3_ff;
         sg4_ff   <= sg3_ff;
         sp4_ff   <= sp3_ff;
         ss4_ff   <= ss3_ff;

         w5_ff    <= w5_in;
         sh5_ff   <= sh5_in;
         eb5_ff   <= eb4_ff;
         zero5_ff <= zero4_ff;
         sg5_ff   <= sg4_ff;
         sp5_ff   <= sp4_ff;
         ss5_ff   <= ss4_ff;

         value_ff <= value_in;
      end
   end

   assign value = value_ff;

endmodule

`default_nettype wire

>>> hw/rtl/fsbd_back.sv
// back end: pops queue entries into two nibble lanes and drives the result channel
// uses fsbd_pkg and fsbd_lane
`default_nettype none

module fsbd_back
   import fsbd_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire fsbd_item_type          q_item,
   input  wire logic                   q_empty,
   output logic                        q_pop,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [TDATA_OUT_W-1:0]      rsp_tdata,
   output logic                        rsp_tlast
);

   typedef struct packed {
      logic [7:0]  low_index;
      logic [7:0]  high_index;
      logic [31:0] row_max;
      logic        last;
   } fsbd_meta_type;

   logic          valid_ff [LANE_STAGES];
   fsbd_meta_type meta_ff  [LANE_STAGES];
   logic          en;
   fsbd_lane_in_type lo_in, hi_in;
   fsbd_half_type d, dmin;
   logic [31:0]   lo_val, hi_val;

   // whole pipe advances unless the held result is refused
   assign en    = !valid_ff[LANE_STAGES-1] || rsp_tready;
   assign q_pop = en && !q_empty;

   assign d    = fsbd_decode(q_item.half_scale);
   assign dmin = fsbd_decode(q_item.half_min_scale);

   always_comb begin
      lo_in.d    = d;
      lo_in.dmin = dmin;
      lo_in.sc   = q_item.sc_a;
      lo_in.mn   = q_item.m_a;
      lo_in.q    = q_item.quant_byte[3:0];
      hi_in.d    = d;
      hi_in.dmin = dmin;
      hi_in.sc   = q_item.sc_b;
      hi_in.mn   = q_item.m_b;
      hi_in.q    = q_item.quant_byte[7:4];
   end

   fsbd_lane u_lane_lo (
      .clock   (clock),
      .en      (en),
      .lane_in (lo_in),
      .value   (lo_val)
   );

   fsbd_lane u_lane_hi (
      .clock   (clock),
      .en      (en),
      .lane_in (hi_in),
      .value   (hi_val)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LANE_STAGES; i++) valid_ff[i] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= !q_empty;
         for (int i = 1; i < LANE_STAGES; i++) valid_ff[i] <= valid_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         meta_ff[0].low_index  <= {q_item.position[6:5], 1'b0, q_item.position[4:0]};
         meta_ff[0].high_index <= {q_item.position[6:5], 1'b1, q_item.position[4:0]};
         meta_ff[0].row_max    <= q_item.row_max;
         meta_ff[0].last       <= q_item.last;
         for (int i = 1; i < LANE_STAGES; i++) meta_ff[i] <= meta_ff[i-1];
      end
   end

   assign rsp_tvalid = valid_ff[LANE_STAGES-1];
   assign rsp_tlast  = meta_ff[LANE_STAGES-1].last;
   assign rsp_tdata  = {meta_ff[LANE_STAGES-1].row_max, meta_ff[LANE_STAGES-1].high_index,
                        hi_val, meta_ff[LANE_STAGES-1].low_index, lo_val};

endmodule

`default_nettype wire

>>> hw/rtl/four_bit_superblock_dequantizer_top.sv
// a quant byte's result word is valid once its entry has passed the queue and the lane stages
// one quant byte per cycle while the queue has room; a header holds ready low while the
// front's single scale multiplier folds the eight sub-block scales into the row max
// reset (synchronous, active high) clears header state, position, row max (+0) and the queue
// top level: front, two-entry queue, back with two nibble lanes; uses fsbd_pkg
`default_nettype none

module four_bit_superblock_dequantizer_top
   import fsbd_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   // input channel
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // half_scale[15:0], half_min_scale[31:16], scales_low[95:32],
   // scales_high[127:96], quant_byte[135:128]
   input  wire logic [TDATA_IN_W-1:0]  req_tdata,
   // command: 0 header, 1 quant byte
   input  wire logic                   req_tuser,
   // last_in_row
   input  wire logic                   req_tlast,
   // result channel
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // low_value[31:0], low_index[39:32], high_value[71:40],
   // high_index[79:72], row_max[111:80]
   output logic [TDATA_OUT_W-1:0]      rsp_tdata,
   // row_end
   output logic                        rsp_tlast
);

   // classified quant bytes from front to back
   fsbd_item_type push_item, head_item;
   logic          q_push, q_full, q_pop, q_empty;

   // header capture, row max fold and position tracking
   fsbd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_item     (push_item)
   );

   // decouples the front from a stalled result channel
   fsbd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (head_item),
      .empty     (q_empty)
   );

   // float arithmetic for both nibbles and the output register
   fsbd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_item     (head_item),
      .q_empty    (q_empty),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

>>> verif/four_bit_superblock_dequantizer_top_tb.sv
// testbench for the four-bit super-block dequantizer: random and directed words with a predictor
// predicts each result word with exact integer arithmetic and its own float32 rounding
// depends on fsbd_pkg and four_bit_superblock_dequantizer_top
`default_nettype none

module four_bit_superblock_dequantizer_top_tb;
   import fsbd_pkg::*;

   localparam logic CMD_HEADER = 1'b0;
   localparam logic CMD_QUANT  = 1'b1;
   localparam int   DRAIN_CYCLES = 20;
   localparam int   LONG_STALL   = 400;
   localparam int   RANDOM_ITEMS = 1850;

   // one expected result word
   typedef struct {
      logic [31:0] low_value;
      logic [7:0]  low_index;
      logic [31:0] high_value;
      logic [7:0]  high_index;
      logic [31:0] row_max;
      logic        row_end;
   } dequant_word_type;

   // dequantizer state copy plus queue of predicted words
   class dequant_scoreboard_type;
      logic [15:0]      d_half;
      logic [15:0]      dmin_half;
      logic [95:0]      scale_bytes;
      logic [6:0]       position;
      logic [31:0]      row_peak;
      dequant_word_type pending[$];
      int               errors;

      function void clear();
         d_half = 0;
         dmin_half = 0;
         scale_bytes = 0;
         position = 0;
         row_peak = 32'h0;
         errors = 0;
         pending.delete();
      endfunction

      // scale and min of sub-block j, 6 bits each
      function void sub_block(input int j, output logic [5:0] sc, output logic [5:0] mn);
         logic [7:0] bj, bj4, bjm4;
         bj = scale_bytes[8*j +: 8];
         bj4 = scale_bytes[8*(j+4) +: 8];
         if (j < 4) begin
            sc = bj[5:0];
            mn = bj4[5:0];
         end else begin
            bjm4 = scale_bytes[8*(j-4) +: 8];
            sc = {bjm4[7:6], bj4[3:0]};
            mn = {bj[7:6], bj4[7:4]};
         end
      endfunction

      // fp16 into class, sign and magnitude in units of 2^-24
      function void decode_half(input logic [15:0] h, output logic is_inf, output logic is_nan,
                                output logic neg, output longint unsigned mag);
         is_inf = (h[14:10] == 5'd31) && (h[9:0] == 0);
         is_nan = (h[14:10] == 5'd31) && (h[9:0] != 0);
         neg = h[15];
         if (h[14:10] == 0) mag = h[9:0];
         else mag = longint'({1'b1, h[9:0]}) << (h[14:10] - 1);
      endfunction

      // round magnitude in units of 2^-24 to float32, nearest even
      function logic [31:0] to_single(input logic neg, input longint unsigned mag);
         int p, sh;
         longint unsigned m, rem, half;
         if (mag == 0) return {neg, 31'b0};
         p = 63;
         while (mag[p] == 1'b0) p--;
         if (p <= 23) begin
            m = mag << (23 - p);
         end else begin
            sh = p - 23;
            m = mag >> sh;
            rem = mag & ((64'd1 << sh) - 1);
            half = 64'd1 << (sh - 1);
            if (rem > half || (rem == half && m[0])) m++;
            if (m == (64'd1 << 24)) begin
               m = m >> 1;
               p++;
            end
         end
         return {neg, 8'(p + 103), m[22:0]};
      endfunction

      // d*sc*q - dmin*mn for one nibble
      function logic [31:0] nibble_value(input logic [5:0] sc, input logic [5:0] mn,
                                         input logic [3:0] q);
         logic d_inf, d_nan, d_neg, m_inf, m_nan, m_neg;
         logic t1_inf, t1_nan, t2_inf, t2_nan, zneg;
         longint unsigned d_mag, m_mag, t1, t2;
         longint diff;
         decode_half(d_half, d_inf, d_nan, d_neg, d_mag);
         decode_half(dmin_half, m_inf, m_nan, m_neg, m_mag);
         t1_nan = d_nan || (d_inf && (sc == 0 || q == 0));
         t1_inf = d_inf && !t1_nan;
         t2_nan = m_nan || (m_inf && mn == 0);
         t2_inf = m_inf && !t2_nan;
         if (t1_nan || t2_nan || (t1_inf && t2_inf && d_neg == m_neg)) return FP32_QNAN;
         if (t1_inf) return {d_neg, FP32_INF};
         if (t2_inf) return {~m_neg, FP32_INF};
         t1 = d_mag * sc * q;
         t2 = m_mag * mn;
         diff = (d_neg ? -longint'(t1) : longint'(t1)) - (m_neg ? -longint'(t2) : longint'(t2));
         if (diff == 0) begin
            // exact cancellation gives +0, only minus zero less plus zero stays negative
            zneg = (t1 == 0 && t2 == 0) ? (d_neg & ~m_neg) : 1'b0;
            return {zneg, 31'b0};
         end
         return to_single(diff < 0, diff < 0 ? -diff : diff);
      endfunction

      // ordered greater-than on non-nan float32 bits
      function logic single_gt(input logic [31:0] a, input logic [31:0] b);
         longint ka, kb;
         ka = a[31] ? -longint'(a[30:0]) : longint'(a[30:0]);
         kb = b[31] ? -longint'(b[30:0]) : longint'(b[30:0]);
         return ka > kb;
      endfunction

      function void note_input(input logic cmd, input logic [TDATA_IN_W-1:0] data,
                               input logic last);
         logic [5:0] sc_a, m_a, sc_b, m_b;
         logic d_inf, d_nan, d_neg;
         longint unsigned d_mag;
         logic [31:0] prod;
         int chunk;
         dequant_word_type w;
         if (cmd == CMD_HEADER) begin
            d_half = data[15:0];
            dmin_half = data[31:16];
            scale_bytes = data[127:32];
            position = 0;
            decode_half(d_half, d_inf, d_nan, d_neg, d_mag);
            for (int j = 0; j < 8; j++) begin
               sub_block(j, sc_a, m_a);
               // nan products never win the ordered compare
               if (d_nan || (d_inf && sc_a == 0)) continue;
               prod = d_inf ? {d_neg, FP32_INF} : to_single(d_neg, d_mag * sc_a);
               if (single_gt(prod, row_peak)) row_peak = prod;
            end
         end else begin
            chunk = position >> 5;
            sub_block(2*chunk, sc_a, m_a);
            sub_block(2*chunk + 1, sc_b, m_b);
            w.low_value = nibble_value(sc_a, m_a, data[131:128]);
            w.high_value = nibble_value(sc_b, m_b, data[135:132]);
            w.low_index = 8'(chunk*64 + position[4:0]);
            w.high_index = 8'(chunk*64 + 32 + position[4:0]);
            w.row_max = row_peak;
            w.row_end = last;
            pending.push_back(w);
            position = position + 1;
            if (last) row_peak = 32'h0;
         end
      endfunction

      function void check_word(input logic [TDATA_OUT_W-1:0] data, input logic last);
         dequant_word_type w;
         if (pending.size() == 0) begin
            $error("result word with nothing expected: %h", data);
            errors++;
            return;
         end
         w = pending.pop_front();
         if (data[31:0] !== w.low_value) begin
            $error("low_value: expected %h, got %h", w.low_value, data[31:0]);
            errors++;
         end
         if (data[39:32] !== w.low_index) begin
            $error("low_index: expected %0d, got %0d", w.low_index, data[39:32]);
            errors++;
         end
         if (data[71:40] !== w.high_value) begin
            $error("high_value: expected %h, got %h", w.high_value, data[71:40]);
            errors++;
         end
         if (data[79:72] !== w.high_index) begin
            $error("high_index: expected %0d, got %0d", w.high_index, data[79:72]);
            errors++;
         end
         if (data[111:80] !== w.row_max) begin
            $error("row_max: expected %h, got %h", w.row_max, data[111:80]);
            errors++;
         end
         if (last !== w.row_end) begin
            $error("row_end: expected %b, got %b", w.row_end, last);
            errors++;
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [TDATA_IN_W-1:0]  req_tdata = '0;
   logic                   req_tuser = 1'b0;
   logic                   req_tlast = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [TDATA_OUT_W-1:0] rsp_tdata;
   logic                   rsp_tlast;

   dequant_scoreboard_type sb = new();
   bit no_idling = 1'b0;     // last part of the run: both sides flat out
   bit hold_request = 1'b0;  // asks the receiver for its long hold-off
   int words_sent = 0;

   four_bit_superblock_dequantizer_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // drive one word from a rising edge; accept is judged at the falling edge before the next
   // rising edge, where every signal is settled
   task automatic send_word(input logic cmd, input logic [TDATA_IN_W-1:0] data,
                            input logic last);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= data;
      req_tlast <= last;
      forever begin
         @(negedge clock);
         if (req_tready) break;
         @(posedge clock);
      end
      sb.note_input(cmd, data, last);
      words_sent++;
      @(posedge clock);
      // occasional idle burst before the next word
      if (!no_idling && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 16);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // header word; the quant byte field is noise and must be ignored
   task automatic send_header(input logic [15:0] d, input logic [15:0] dmin,
                              input logic [95:0] scales);
      send_word(CMD_HEADER, {8'($urandom), scales, dmin, d}, 1'($urandom));
   endtask

   // quant byte word with random noise in the header fields
   task automatic send_quant(input logic [7:0] q, input logic last);
      send_word(CMD_QUANT, {q, 32'($urandom), 64'({$urandom, $urandom}), 32'($urandom)}, last);
   endtask

   // fp16 pattern biased towards finite values, with the odd special
   function automatic logic [15:0] pick_half();
      case ($urandom_range(0, 9))
         0: return {1'($urandom), 5'd31, 10'($urandom_range(0, 1) ? 0 : $urandom)};
         1: return {1'($urandom), 5'd0, 10'($urandom)};
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [95:0] pick_scales();
      return {$urandom, $urandom, $urandom};
   endfunction

   // receiver: random stall bursts, one long hold-off on request, none at the end
   initial begin
      int stall;
      bit held;
      held = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request && !held) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (LONG_STALL) @(posedge clock);
         end else if (!no_idling && $urandom_range(0, 7) == 0) begin
            stall = $urandom_range(1, 16);
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clock);
         end
      end
   end

   // result monitor at the falling edge, ahead of the accepting rising edge
   always @(negedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_word(rsp_tdata, rsp_tlast);
   end

   initial begin
      int n;
      sb.clear();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: bytes before any header see the all-zero state
      send_quant(8'h00, 1'b0);
      send_quant(8'hFF, 1'b1);
      // largest finite scales and all-ones packed scales
      send_header(16'h7BFF, 16'h7BFF, '1);
      send_quant(8'hFF, 1'b0);
      send_quant(8'h0F, 1'b0);
      send_quant(8'hF0, 1'b1);
      // subnormal and negative scales, sign of zero in the differences
      send_header(16'h0001, 16'h83FF, 96'h0123_4567_89AB_CDEF_FEDC_BA98);
      send_quant(8'h00, 1'b0);
      send_quant(8'hA5, 1'b0);
      send_header(16'h8000, 16'h0000, '0);
      send_quant(8'h00, 1'b0);
      send_header(16'h8000, 16'h8000, '0);
      send_quant(8'h00, 1'b1);
      // infinite scale: products of zero give nan, the rest infinity
      send_header(16'h7C00, 16'h7C00, 96'h3F00_0000_0000_0000_0000_003F);
      send_quant(8'h10, 1'b0);
      send_quant(8'h01, 1'b1);
      // nan scales and opposite infinities
      send_header(16'hFE01, 16'hFC00, '1);
      send_quant(8'h55, 1'b0);
      send_header(16'hFC00, 16'h7C00, '1);
      send_quant(8'hFF, 1'b1);

      // random: mostly whole super-blocks, some wrapping, some noise
      while (words_sent < RANDOM_ITEMS) begin
         if (words_sent > RANDOM_ITEMS - 300) no_idling = 1'b1;
         if (words_sent > 600) hold_request = 1'b1;
         if ($urandom_range(0, 4) != 0) begin
            send_header(pick_half(), pick_half(), pick_scales());
            // a few runs go past 128 bytes and wrap onto the same header
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(129, 150) : 128;
            for (int i = 0; i < n; i++)
               send_quant(8'($urandom),
                          (i == n - 1) ? 1'($urandom_range(0, 2) == 0) : 1'b0);
         end else begin
            n = $urandom_range(1, 20);
            for (int i = 0; i < n; i++) begin
               if ($urandom_range(0, 5) == 0)
                  send_header(pick_half(), pick_half(), pick_scales());
               else
                  send_quant(8'($urandom), 1'($urandom_range(0, 9) == 0));
            end
         end
      end
      req_tvalid <= 1'b0;

      while (sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         if (sb.pending.size() != 0) $error("%0d result words never arrived", sb.pending.size());
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // watchdog
   initial begin
      #4000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

`default_nettype wire

>>> sim.f
hw/rtl/fsbd_pkg.sv
hw/rtl/fsbd_front.sv
hw/rtl/fsbd_queue.sv
hw/rtl/fsbd_lane.sv
hw/rtl/fsbd_back.sv
hw/rtl/four_bit_superblock_dequantizer_top.sv
verif/four_bit_superblock_dequantizer_top_tb.sv
